// File: rtl/bhpq_pkg.sv
package bhpq_pkg;

    localparam int DEFAULT_CAPACITY  = 256;
    localparam int DEFAULT_KEY_WIDTH = 32;
    localparam int DEFAULT_TAG_WIDTH = 16;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_ROOT,
        S_TAKE,
        S_RD_LAST,
        S_POP_LAST,
        S_AFTER_LAST,
        S_SU_CHK,
        S_SU_RD,
        S_SU_CMP,
        S_SD_CHK,
        S_SD_RDL,
        S_SD_LATL,
        S_SD_RDR,
        S_SD_CMPR,
        S_SD_DEC,
        S_SC_RD,
        S_SC_CMP,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_SET_NOTFOUND,
        OP_PUSH_START,
        OP_RD_ROOT,
        OP_TAKE_OUT,
        OP_RD_LAST,
        OP_POP_LAST,
        OP_SU_RD,
        OP_SU_MOVE,
        OP_WR_E,
        OP_SD_RDL,
        OP_SD_LATL,
        OP_SD_RDR,
        OP_SD_CMPR,
        OP_SD_MOVE,
        OP_SC_RD,
        OP_SC_NEXT,
        OP_SC_HIT,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       cnt_zero;
        logic       cnt_full;
        logic       hole_zero;
        logic       hole_last;
        logic       su_beats;
        logic       left_out;
        logic       right_out;
        logic       sd_beats;
        logic       tag_hit;
        logic       scan_end;
        logic       out_free;
    } dp_stat_t;

endpackage

// File: rtl/bhpq_ctrl.sv
module bhpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bhpq_pkg::dp_stat_t stat,
    output bhpq_pkg::dp_op_t   op
);
    import bhpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_PUSH:
                    begin
                        if (stat.cnt_full)
                        begin
                            op         = OP_SET_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_PUSH_START;
                            state_next = S_SU_CHK;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.cnt_zero)
                        begin
                            op         = OP_SET_NOTFOUND;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SC_RD;
                        end
                    end
                    default:
                    begin
                        if (stat.cnt_zero)
                        begin
                            op         = OP_SET_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_RD_ROOT;
                        end
                    end
                endcase
            end
            S_RD_ROOT:
            begin
                op         = OP_RD_ROOT;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                op         = OP_TAKE_OUT;
                state_next = (stat.cmd == CMD_POP) ? S_RD_LAST : S_FINISH;
            end
            S_RD_LAST:
            begin
                op         = OP_RD_LAST;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                op         = OP_POP_LAST;
                state_next = S_AFTER_LAST;
            end
            S_AFTER_LAST:
            begin
                // The removed slot was the last one, so nothing has to move.
                if (stat.hole_last)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.cmd == CMD_REMOVE)
                begin
                    state_next = S_SU_CHK;
                end
                else
                begin
                    state_next = S_SD_CHK;
                end
            end
            S_SU_CHK:
            begin
                if (!stat.hole_zero)
                begin
                    state_next = S_SU_RD;
                end
                else if (stat.cmd == CMD_REMOVE)
                begin
                    state_next = S_SD_CHK;
                end
                else
                begin
                    op         = OP_WR_E;
                    state_next = S_FINISH;
                end
            end
            S_SU_RD:
            begin
                op         = OP_SU_RD;
                state_next = S_SU_CMP;
            end
            S_SU_CMP:
            begin
                if (stat.su_beats)
                begin
                    op         = OP_SU_MOVE;
                    state_next = S_SU_CHK;
                end
                else if (stat.cmd == CMD_REMOVE)
                begin
                    state_next = S_SD_CHK;
                end
                else
                begin
                    op         = OP_WR_E;
                    state_next = S_FINISH;
                end
            end
            S_SD_CHK:
            begin
                if (stat.left_out)
                begin
                    op         = OP_WR_E;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SD_RDL;
                end
            end
            S_SD_RDL:
            begin
                op         = OP_SD_RDL;
                state_next = S_SD_LATL;
            end
            S_SD_LATL:
            begin
                op         = OP_SD_LATL;
                state_next = stat.right_out ? S_SD_DEC : S_SD_RDR;
            end
            S_SD_RDR:
            begin
                op         = OP_SD_RDR;
                state_next = S_SD_CMPR;
            end
            S_SD_CMPR:
            begin
                op         = OP_SD_CMPR;
                state_next = S_SD_DEC;
            end
            S_SD_DEC:
            begin
                if (stat.sd_beats)
                begin
                    op         = OP_SD_MOVE;
                    state_next = S_SD_CHK;
                end
                else
                begin
                    op         = OP_WR_E;
                    state_next = S_FINISH;
                end
            end
            S_SC_RD:
            begin
                op         = OP_SC_RD;
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (stat.tag_hit)
                begin
                    op         = OP_SC_HIT;
                    state_next = S_RD_LAST;
                end
                else if (stat.scan_end)
                begin
                    op         = OP_SET_NOTFOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = OP_SC_NEXT;
                    state_next = S_SC_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    op         = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bhpq_datapath.sv
module bhpq_datapath #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bhpq_pkg::dp_op_t     op,
    output bhpq_pkg::dp_stat_t   stat,
    input  logic                 order_select,
    input  logic [1:0]           cmd,
    input  logic [KEY_WIDTH-1:0] entry_key,
    input  logic [TAG_WIDTH-1:0] entry_tag,
    input  logic [TAG_WIDTH-1:0] match_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [KEY_WIDTH-1:0] out_key,
    output logic [TAG_WIDTH-1:0] out_tag,
    output logic [CNT_W-1:0]     out_count
);
    import bhpq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int EXT_W = IDX_W + 2;
    localparam int ENT_W = KEY_WIDTH + TAG_WIDTH;

    logic [ENT_W-1:0] mem [CAPACITY];

    logic [ENT_W-1:0]     rd_reg;
    logic [ENT_W-1:0]     e_reg;
    logic [ENT_W-1:0]     child_reg;
    logic [IDX_W-1:0]     cidx_reg;
    logic [IDX_W-1:0]     hole_reg;
    logic [IDX_W-1:0]     scan_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [TAG_WIDTH-1:0] match_reg;
    logic [1:0]           w_status_reg;
    logic [KEY_WIDTH-1:0] w_key_reg;
    logic [TAG_WIDTH-1:0] w_tag_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [KEY_WIDTH-1:0] out_key_reg;
    logic [TAG_WIDTH-1:0] out_tag_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic [EXT_W-1:0] hole_ext;
    logic [EXT_W-1:0] left_ext;
    logic [EXT_W-1:0] right_ext;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] scan_ext;
    logic [IDX_W-1:0] parent_idx;
    logic [IDX_W-1:0] last_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    // True when key a belongs strictly closer to the root than key b.
    function automatic logic beats(input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b,
                                   input logic                 min_first);
        return min_first ? (a < b) : (a > b);
    endfunction

    assign hole_ext   = EXT_W'(hole_reg);
    assign left_ext   = (hole_ext << 1) + EXT_W'(1);
    assign right_ext  = (hole_ext << 1) + EXT_W'(2);
    assign cnt_ext    = EXT_W'(cnt_reg);
    assign scan_ext   = EXT_W'(scan_reg) + EXT_W'(1);
    assign parent_idx = (hole_reg - IDX_W'(1)) >> 1;
    assign last_idx   = IDX_W'(cnt_reg - CNT_W'(1));

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.cnt_zero  = (cnt_reg == '0);
        stat.cnt_full  = (cnt_ext == EXT_W'(CAPACITY));
        stat.hole_zero = (hole_reg == '0);
        stat.hole_last = (hole_ext == cnt_ext);
        stat.su_beats  = beats(e_reg[ENT_W-1:TAG_WIDTH], rd_reg[ENT_W-1:TAG_WIDTH],
                               order_select);
        stat.left_out  = (left_ext >= cnt_ext);
        stat.right_out = (right_ext >= cnt_ext);
        stat.sd_beats  = beats(child_reg[ENT_W-1:TAG_WIDTH], e_reg[ENT_W-1:TAG_WIDTH],
                               order_select);
        stat.tag_hit   = (rd_reg[TAG_WIDTH-1:0] == match_reg);
        stat.scan_end  = (scan_ext >= cnt_ext);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = hole_reg;
        wr_data = e_reg;
        case (op)
            OP_RD_ROOT:
            begin
                rd_en = 1'b1;
            end
            OP_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = last_idx;
            end
            OP_SU_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = parent_idx;
            end
            OP_SD_RDL:
            begin
                rd_en   = 1'b1;
                rd_addr = left_ext[IDX_W-1:0];
            end
            OP_SD_RDR:
            begin
                rd_en   = 1'b1;
                rd_addr = right_ext[IDX_W-1:0];
            end
            OP_SC_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = scan_reg;
            end
            OP_WR_E:
            begin
                wr_en = 1'b1;
            end
            OP_SU_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = rd_reg;
            end
            OP_SD_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = child_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // The moving entry stays in e_reg while the open slot walks; it is
    // written once where it comes to rest.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg      <= cmd;
                key_reg      <= entry_key;
                tag_reg      <= entry_tag;
                match_reg    <= match_tag;
                hole_reg     <= '0;
                scan_reg     <= '0;
                w_status_reg <= ST_OK;
                w_key_reg    <= '0;
                w_tag_reg    <= '0;
            end
            OP_SET_FULL:     w_status_reg <= ST_FULL;
            OP_SET_EMPTY:    w_status_reg <= ST_EMPTY;
            OP_SET_NOTFOUND: w_status_reg <= ST_NOTFOUND;
            OP_PUSH_START:
            begin
                e_reg    <= {key_reg, tag_reg};
                hole_reg <= cnt_reg[IDX_W-1:0];
            end
            OP_TAKE_OUT:
            begin
                w_key_reg <= rd_reg[ENT_W-1:TAG_WIDTH];
                w_tag_reg <= rd_reg[TAG_WIDTH-1:0];
            end
            OP_POP_LAST:
            begin
                e_reg <= rd_reg;
            end
            OP_SU_MOVE:
            begin
                hole_reg <= parent_idx;
            end
            OP_SD_LATL:
            begin
                child_reg <= rd_reg;
                cidx_reg  <= left_ext[IDX_W-1:0];
            end
            OP_SD_CMPR:
            begin
                if (beats(rd_reg[ENT_W-1:TAG_WIDTH], child_reg[ENT_W-1:TAG_WIDTH],
                          order_select))
                begin
                    child_reg <= rd_reg;
                    cidx_reg  <= right_ext[IDX_W-1:0];
                end
            end
            OP_SD_MOVE:
            begin
                hole_reg <= cidx_reg;
            end
            OP_SC_NEXT:
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            OP_SC_HIT:
            begin
                w_key_reg <= rd_reg[ENT_W-1:TAG_WIDTH];
                w_tag_reg <= rd_reg[TAG_WIDTH-1:0];
                hole_reg  <= scan_reg;
            end
            default:
            begin
                hole_reg <= hole_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_PUSH_START)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (op == OP_POP_LAST)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (op == OP_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_DONE)
        begin
            out_status_reg <= w_status_reg;
            out_key_reg    <= w_key_reg;
            out_tag_reg    <= w_tag_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign out_count = out_count_reg;

endmodule

// File: rtl/binary_heap_priority_queue.sv
// Binary heap priority queue of (key, tag) words held in one single-port
// array with a registered read. Words are taken one at a time: in_ready is
// high only while no command is in progress, and the result sits in an
// output register, so the next word can be taken while it waits. Peek
// reads the root; push places the new entry at the end and sifts it up
// one level per step. Pop takes the root out, moves the last entry into
// its place and sifts it down, comparing the children at each level; with
// a capacity of 256 a sift passes at most 8 levels. The steps of a sift
// are paced by the memory reads. Remove scans the tags first, slot by
// slot, then refills the found slot with the last entry and sifts it up
// and down.
module binary_heap_priority_queue #(
    parameter int CAPACITY  = bhpq_pkg::DEFAULT_CAPACITY,
    parameter int KEY_WIDTH = bhpq_pkg::DEFAULT_KEY_WIDTH,
    parameter int TAG_WIDTH = bhpq_pkg::DEFAULT_TAG_WIDTH,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [KEY_WIDTH-1:0] entry_key,
    input  logic [TAG_WIDTH-1:0] entry_tag,
    input  logic [TAG_WIDTH-1:0] match_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [KEY_WIDTH-1:0] out_key,
    output logic [TAG_WIDTH-1:0] out_tag,
    output logic [CNT_W-1:0]     out_count
);
    import bhpq_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;
    logic     order_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            order_reg <= cfg_data;
        end
    end

    bhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    bhpq_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .CNT_W     (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .order_select (order_reg),
        .cmd          (cmd),
        .entry_key    (entry_key),
        .entry_tag    (entry_tag),
        .match_tag    (match_tag),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_key      (out_key),
        .out_tag      (out_tag),
        .out_count    (out_count)
    );

    // A push never leaves more entries than the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // An accepted word always leaves the controller busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a word was taken");

    // Error results carry a zero key.
    a_error_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (out_key == '0))
        else $error("error result with a nonzero key");

endmodule
